// ===== sv/dtr_pkg.sv =====
// Shared types, codes and helpers for the divider timer with reload delay.
// Used by dtr_core and divider_timer_with_reload_delay; no dependencies.
package dtr_pkg;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register select codes
	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_CNT  = 2'd1;
	localparam logic [1:0] REG_MOD  = 2'd2;
	localparam logic [1:0] REG_CTRL = 2'd3;

	// Overflow phase milestones
	localparam logic [2:0] PHASE_IRQ    = 3'd4;
	localparam logic [2:0] PHASE_RELOAD = 3'd5;
	localparam logic [2:0] PHASE_LAST   = 3'd6;

	// Control register enable bit
	localparam int CTRL_EN_BIT = 2;

	// Bus widths
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 16;

	typedef struct packed {
		logic [7:0] write_data;
		logic [1:0] reg_select;
		logic [1:0] operation;
	} item_t;

	typedef struct packed {
		logic       timer_interrupt;
		logic [7:0] read_data;
	} result_t;

	// Divider bit position for a control select code, doubled in double speed
	function automatic logic [4:0] sel_pos(input logic [1:0] sel, input logic dbl);
		logic [4:0] base;
		case (sel)
			2'd0:    base = 5'd9;
			2'd1:    base = 5'd3;
			2'd2:    base = 5'd5;
			default: base = 5'd7;
		endcase
		sel_pos = dbl ? {base[3:0], 1'b0} : base;
	endfunction

	// Selected divider bit; a position above fifteen reads as zero
	function automatic logic div_bit(input logic [15:0] div, input logic [4:0] pos);
		div_bit = pos[4] ? 1'b0 : div[pos[3:0]];
	endfunction

endpackage

// ===== sv/dtr_core.sv =====
// Timer state and per-item update: divider, counter, modulo, control,
// edge detector and overflow phase. Depends on dtr_pkg.
module dtr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic             double_speed,
	input  dtr_pkg::item_t   item,
	output dtr_pkg::result_t result
);
	import dtr_pkg::*;

	logic [15:0] div_q;
	logic [7:0]  cnt_q;
	logic [7:0]  mod_q;
	logic [7:0]  ctrl_q;
	logic        prev_bit_q;
	logic        ovf_pending_q;
	logic [2:0]  ovf_phase_q;

	logic        is_tick, is_write, is_read;
	logic [15:0] div_new;
	logic        run_edge, sel_bit, fall;
	logic [7:0]  cnt_inc;
	logic        wrap;
	logic [7:0]  cnt_a;
	logic        pend_a;
	logic [2:0]  ph_a, ph_b;
	logic [7:0]  cnt_d, mod_d, ctrl_d;
	logic        pend_d, prev_d;
	logic [2:0]  ph_d;
	logic        irq;
	logic [7:0]  rd;

	assign is_tick  = (item.operation == OP_TICK);
	assign is_write = (item.operation == OP_WRITE);
	assign is_read  = (item.operation == OP_READ);

	// Advance or clear the divider and run edge detection on the chosen bit
	assign run_edge = is_tick || (is_write && item.reg_select == REG_DIV);
	assign div_new  = is_tick ? div_q + 16'd1 : (run_edge ? 16'd0 : div_q);
	assign sel_bit  = div_bit(div_new, sel_pos(ctrl_q[1:0], double_speed))
		&& ctrl_q[CTRL_EN_BIT];
	assign fall     = run_edge && !sel_bit && prev_bit_q;
	assign cnt_inc  = cnt_q + 8'd1;
	assign wrap     = fall && (cnt_inc == 8'd0);
	assign cnt_a    = fall ? cnt_inc : cnt_q;
	assign pend_a   = ovf_pending_q || wrap;
	assign ph_a     = wrap ? 3'd0 : ovf_phase_q;
	assign ph_b     = ph_a + 3'd1;
	assign prev_d   = run_edge ? sel_bit : prev_bit_q;

	// Resolve next state for the item
	always_comb begin
		cnt_d  = cnt_a;
		mod_d  = mod_q;
		ctrl_d = ctrl_q;
		pend_d = pend_a;
		ph_d   = ph_a;
		irq    = 1'b0;
		if (is_tick && pend_a) begin
			ph_d = ph_b;
			if (ph_b == PHASE_IRQ) begin
				irq = 1'b1;
			end else if (ph_b == PHASE_RELOAD) begin
				cnt_d = mod_q;
			end else if (ph_b == PHASE_LAST) begin
				cnt_d  = mod_q;
				pend_d = 1'b0;
				ph_d   = 3'd0;
			end
		end
		if (is_write) begin
			case (item.reg_select)
				REG_CNT: begin
					if (ovf_phase_q < PHASE_RELOAD) begin
						cnt_d  = item.write_data;
						pend_d = 1'b0;
						ph_d   = 3'd0;
					end
				end
				REG_MOD:  mod_d  = item.write_data;
				REG_CTRL: ctrl_d = item.write_data;
				default: ;
			endcase
		end
	end

	// Select read byte
	always_comb begin
		rd = 8'd0;
		if (is_read) begin
			case (item.reg_select)
				REG_DIV: rd = div_q[15:8];
				REG_CNT: rd = cnt_q;
				REG_MOD: rd = mod_q;
				default: rd = ctrl_q;
			endcase
		end
	end

	assign result.read_data       = rd;
	assign result.timer_interrupt = irq;

	// Commit state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q         <= 16'd0;
			cnt_q         <= 8'd0;
			mod_q         <= 8'd0;
			ctrl_q        <= 8'd0;
			prev_bit_q    <= 1'b0;
			ovf_pending_q <= 1'b0;
			ovf_phase_q   <= 3'd0;
		end else if (step_en) begin
			div_q         <= div_new;
			cnt_q         <= cnt_d;
			mod_q         <= mod_d;
			ctrl_q        <= ctrl_d;
			prev_bit_q    <= prev_d;
			ovf_pending_q <= pend_d;
			ovf_phase_q   <= ph_d;
		end
	end

	a_phase_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_phase_q != 3'd0 |-> ovf_pending_q)
		else $error("overflow phase running without pending overflow");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_phase_q <= PHASE_LAST)
		else $error("overflow phase past its last step");

	a_irq_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && irq |=> ovf_pending_q && ovf_phase_q == PHASE_IRQ)
		else $error("interrupt raised outside phase four");

endmodule

// ===== sv/divider_timer_with_reload_delay.sv =====
// Divider timer with reload delay: input stage, timer core, result register.
// Depends on dtr_pkg and dtr_core.
// An accepted item is registered in the input stage; its result is then registered in the result register.
// Throughput: one item per cycle while m_tready does not stall; dtr_core updates its state per item.
// Input and result registers form a two-stage pipe that stalls only on m_tready.
// Reset clears all timer state, double_speed and both stage valid flags.
module divider_timer_with_reload_delay (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dtr_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] write_data
	input  logic [dtr_pkg::S_TUSER_W-1:0]  s_tuser,  // [1:0] operation, [3:2] reg_select
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dtr_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] read_data, [8] timer_interrupt
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data
);
	import dtr_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t core_result;
	logic    advance;
	logic    double_speed_q;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_speed_q <= 1'b0;
		end else if (cfg_valid) begin
			double_speed_q <= cfg_data;
		end
	end

	// Capture input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation  <= s_tuser[1:0];
			item_s1.reg_select <= s_tuser[3:2];
			item_s1.write_data <= s_tdata[7:0];
		end
	end

	dtr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.double_speed (double_speed_q),
		.item         (item_s1),
		.result       (core_result)
	);

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result_q.timer_interrupt, result_q.read_data};

endmodule
